// File: hw/rtl/xor_checked_frame_builder_top_defines.svh
// Assertion macros shared by the frame builder checker.
`ifndef XOR_CHECKED_FRAME_BUILDER_TOP_DEFINES_SVH
`define XOR_CHECKED_FRAME_BUILDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define XCFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define XCFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/xcfb_pkg.sv
// Types and constants of the XOR-checked frame builder.
package xcfb_pkg;

	localparam logic [7:0] SYNC_BYTE     = 8'hFD;
	localparam logic [7:0] LEN_HIGH_BYTE = 8'h00;
	localparam logic [7:0] LEN_EXTRA     = 8'd3;
	localparam logic [7:0] CMD_RESET     = 8'h01;
	localparam logic [7:0] ENC_RESET     = 8'h00;

	// configuration register indexes
	localparam logic REG_COMMAND  = 1'b0;
	localparam logic REG_ENCODING = 1'b1;

	// one classified item, front to back
	typedef struct packed {
		logic       start;     // opens a frame: header goes out first
		logic       last;      // last payload byte: checksum follows
		logic [7:0] data;
		logic [7:0] len_byte;  // low length byte of the header
	} frame_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// File: hw/rtl/xcfb_front.sv
// Front end: accepts items, tracks the open frame, classifies each item.
module xcfb_front import xcfb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    data_byte,
	input  logic          frame_start,
	input  logic [7:0]    frame_len,
	input  queue_status_t qstat,
	output logic          push,
	output frame_cmd_t    push_cmd
);

	logic       accept;
	logic [7:0] len_eff;
	logic [7:0] rem_q;
	logic       in_frame_q;

	assign in_stall = qstat.full;
	assign accept   = in_valid & ~qstat.full;
	// zero length is taken as one
	assign len_eff  = (frame_len == 8'd0) ? 8'd1 : frame_len;
	// bytes outside a frame are dropped here
	assign push     = accept & (frame_start | in_frame_q);

	always_comb begin
		push_cmd.start    = frame_start;
		push_cmd.data     = data_byte;
		push_cmd.len_byte = len_eff + LEN_EXTRA;
		push_cmd.last     = frame_start ? (len_eff == 8'd1) : (rem_q == 8'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			in_frame_q <= 1'b0;
		end else if (accept) begin
			if (frame_start) begin
				rem_q      <= len_eff - 8'd1;
				in_frame_q <= (len_eff != 8'd1);
			end else if (in_frame_q) begin
				rem_q      <= rem_q - 8'd1;
				in_frame_q <= (rem_q != 8'd1);
			end
		end
	end

endmodule

// File: hw/rtl/xcfb_queue.sv
// Short show-ahead queue of classified items between front and back.
module xcfb_queue import xcfb_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  frame_cmd_t    push_cmd,
	input  logic          pop,
	output frame_cmd_t    head,
	output queue_status_t qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push & ~qstat.full;
	assign do_pop      = pop & ~qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push & ~do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop & ~do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/xcfb_back.sv
// Back end: expands queued items into frame bytes, keeps checksum and config.
module xcfb_back import xcfb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data,
	input  frame_cmd_t    head,
	input  queue_status_t qstat,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          end_of_frame
);

	localparam logic [2:0] ST_SYNC   = 3'd0;
	localparam logic [2:0] ST_LEN_HI = 3'd1;
	localparam logic [2:0] ST_LEN_LO = 3'd2;
	localparam logic [2:0] ST_CMD    = 3'd3;
	localparam logic [2:0] ST_ENC    = 3'd4;
	localparam logic [2:0] ST_DATA   = 3'd5;
	localparam logic [2:0] ST_CSUM   = 3'd6;

	logic [7:0] cmd_q;
	logic [7:0] enc_q;
	logic [7:0] xor_q;
	logic [2:0] step_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       eof_q;

	logic       slot_free;
	logic       fire;
	logic       done;
	logic [2:0] cur_step;
	logic [7:0] byte_nxt;
	logic       eof_nxt;

	assign slot_free = ~out_valid_q | ~out_stall;
	assign fire      = slot_free & ~qstat.empty;
	// a payload item starts at the data step, a start item at the sync byte
	assign cur_step  = busy_q ? step_q : (head.start ? ST_SYNC : ST_DATA);
	assign done      = (cur_step == ST_CSUM) | ((cur_step == ST_DATA) & ~head.last);
	assign pop       = fire & done;

	always_comb begin
		eof_nxt = 1'b0;
		unique case (cur_step)
			ST_SYNC:   byte_nxt = SYNC_BYTE;
			ST_LEN_HI: byte_nxt = LEN_HIGH_BYTE;
			ST_LEN_LO: byte_nxt = head.len_byte;
			ST_CMD:    byte_nxt = cmd_q;
			ST_ENC:    byte_nxt = enc_q;
			ST_DATA:   byte_nxt = head.data;
			ST_CSUM: begin
				byte_nxt = xor_q;
				eof_nxt  = 1'b1;
			end
			default:   byte_nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_RESET;
			enc_q <= ENC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COMMAND:  cmd_q <= cfg_data;
				REG_ENCODING: enc_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_SYNC;
			xor_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				busy_q <= ~done;
				step_q <= cur_step + 3'd1;
				if (cur_step == ST_SYNC) begin
					xor_q <= SYNC_BYTE;
				end else if (cur_step == ST_CSUM) begin
					xor_q <= '0;
				end else begin
					xor_q <= xor_q ^ byte_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= byte_nxt;
			eof_q      <= eof_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign end_of_frame = eof_q;

endmodule

// File: hw/rtl/xor_checked_frame_builder_top.sv
// Top level of the XOR-checked frame builder.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall   | data_byte, frame_start, frame_len
//  out     | from block| out_valid / out_stall | out_byte, end_of_frame
//  cfg     | to block  | cfg_we                | cfg_index, cfg_data
//
// Payload items give one byte per cycle unless out_stall holds the output,
// and the last byte of a frame is followed by the checksum. A start item
// emits the header (sync, length high and low, command, encoding) and its
// data byte, plus the checksum for a one-byte frame; the item queue
// (QUEUE_DEPTH entries) lets input run ahead meanwhile, and in_stall rises
// only when it is full. The output register takes the next byte whenever
// it is empty or taken. Reset is asynchronous, active low; it clears frame
// state, the queue and restores command_code = 1, encoding_code = 0.
module xor_checked_frame_builder_top import xcfb_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  logic [7:0] frame_len,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       end_of_frame,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	queue_status_t qstat;
	logic          push;
	logic          pop;
	frame_cmd_t    push_cmd;
	frame_cmd_t    head;

	// frame tracking and drop of stray bytes
	xcfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_len   (frame_len),
		.qstat       (qstat),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// decouples header bursts from the input stream
	xcfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// byte sequencer, checksum and output register
	xcfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame)
	);

endmodule

// File: hw/rtl/xcfb_checker.sv
// Port-level checker of the frame builder, bound to the top level.
`include "xor_checked_frame_builder_top_defines.svh"

module xcfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       frame_start,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       end_of_frame
);

	// stalled output item holds
	`XCFB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(end_of_frame), "output item changed under stall")

	// after a checksum only a new header can follow
	`XCFB_ASSERT_NEXT(a_sync_after_eof, out_valid && !out_stall && end_of_frame, !out_valid || (out_byte == 8'hFD), "byte after frame end is not a sync byte")

	// an accepted start item must be followed by valid output
	`XCFB_ASSERT_NOW(a_start_latency, in_valid && !in_stall && frame_start, ##2 out_valid, "no output after start item")

endmodule

bind xor_checked_frame_builder_top xcfb_checker u_chk (.*);
